>>> design/gurwj_pkg.sv
// ----------------------------------------------------------------------------
// gurwj_pkg
// shared codes and journal entry layout for the grouped undo/redo journal
// ----------------------------------------------------------------------------
package gurwj_pkg;

  // opcodes
  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_UNDO  = 3'd1;
  localparam logic [2:0] OP_REDO  = 3'd2;
  localparam logic [2:0] OP_OPEN  = 3'd3;
  localparam logic [2:0] OP_CLOSE = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // mark bits
  localparam int unsigned GRP_START_BIT = 0;
  localparam int unsigned GRP_END_BIT   = 1;

  // journal entry layout: addr | mark | old | new
  localparam int unsigned NEW_LSB = 0;
  localparam int unsigned OLD_LSB = 8;
  localparam int unsigned MK_LSB  = 16;
  localparam int unsigned AD_LSB  = 18;

  // saturation of the applied-entry count
  localparam logic [10:0] COUNT_MAX = 11'h7ff;

endpackage

>>> design/gurwj_ram.sv
// ----------------------------------------------------------------------------
// gurwj_ram
// generic single-port synchronous ram, registered read data
// ----------------------------------------------------------------------------
module gurwj_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/grouped_undo_redo_write_journal_unit.sv
// ----------------------------------------------------------------------------
// grouped_undo_redo_write_journal_unit
// byte image with a journal of writes, grouped undo and redo
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i/in_ready_o) carries one command item: opcode,
//   address, value and mark. output channel (out_valid_o/out_ready_i)
//   returns exactly one result item per command: read_data, status and
//   entries_applied.
//   the block works on one item at a time; in_ready_o is high in idle and
//   the next item can be taken in the cycle after the previous result is loaded.
//   open group, close with nothing to mark, refused or empty ops finish in
//   the decode state; read, write and close group then pass through their
//   own state (S_RD, S_WR, S_CLOSE); undo / redo walk the journal entries,
//   one per cycle.
//   the walk rate is set by the journal ram port: one entry read per cycle
//   while the image ram takes the restored byte. the address wrap takes the
//   decode cycle (reciprocal multiply at accept, multiply-subtract after).
//   the output register lets a result wait while the next item is accepted;
//   a finished item whose result cannot be loaded waits in a hold state.
//   after reset the image ram is cleared, one byte per cycle; no item is
//   accepted during that pass. the journal needs no clearing, only entries
//   below top are ever read.
// ----------------------------------------------------------------------------
module grouped_undo_redo_write_journal_unit #(
  parameter int unsigned IMAGE_BYTES   = 4096,
  parameter int unsigned JOURNAL_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [11:0] address_i,
  input  logic [7:0]  value_i,
  input  logic [1:0]  mark_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic [1:0]  status_o,
  output logic [10:0] entries_applied_o
);

  import gurwj_pkg::*;

  // widths derived from the configuration
  localparam int unsigned AW  = $clog2(IMAGE_BYTES);
  localparam int unsigned JIW = $clog2(JOURNAL_DEPTH);
  localparam int unsigned CW  = $clog2(JOURNAL_DEPTH + 1);
  localparam int unsigned JW  = AW + AD_LSB;

  // address wrap: identity when the image covers the 12-bit field,
  // otherwise q = floor(addr / IMAGE_BYTES) by an exact reciprocal
  localparam bit          WRAP_ID = (IMAGE_BYTES >= 4096);
  localparam int unsigned RECIP   = WRAP_ID ? 1 : ((2**24 + IMAGE_BYTES - 1) / IMAGE_BYTES);

  // controller states
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_WR    = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_UNDO  = 4'd5;
  localparam logic [3:0] S_REDO  = 4'd6;
  localparam logic [3:0] S_CLOSE = 4'd7;
  localparam logic [3:0] S_HOLD  = 4'd8;

  // control state
  logic [3:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [CW-1:0] cursor_q, cursor_d;
  logic [CW-1:0] top_q, top_d;
  logic          ps_q, ps_d;
  logic [CW-1:0] rp_q, rp_d;
  logic [10:0]   cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;

  // captured item and derived payload
  logic [2:0]    op_q, op_d;
  logic [11:0]   addr_q, addr_d;
  logic [7:0]    value_q, value_d;
  logic [1:0]    mark_q, mark_d;
  logic [8:0]    quo_q, quo_d;
  logic [AW-1:0] waddr_q, waddr_d;

  // result registers
  logic [7:0]  rd_out_q, rd_out_d;
  logic [1:0]  st_out_q, st_out_d;
  logic [10:0] cnt_out_q, cnt_out_d;
  logic [7:0]  rd_hold_q, rd_hold_d;
  logic [1:0]  st_hold_q, st_hold_d;
  logic [10:0] cnt_hold_q, cnt_hold_d;

  // ram ports
  logic [AW-1:0]  img_addr;
  logic           img_we;
  logic [7:0]     img_wdata;
  logic [7:0]     img_rdata;
  logic [JIW-1:0] jrn_addr;
  logic           jrn_we;
  logic [JW-1:0]  jrn_wdata;
  logic [JW-1:0]  jrn_rdata;

  // helpers
  logic [32:0]   quo_prod;
  logic [31:0]   qn_full;
  logic [11:0]   rem12;
  logic [AW-1:0] wa;
  logic [CW-1:0] cur_m1;
  logic [CW-1:0] rp_m1;
  logic [CW-1:0] rp_p1;
  logic [10:0]   cnt_inc;
  logic          out_free;
  logic          done;
  logic [7:0]    res_rd;
  logic [1:0]    res_st;
  logic [10:0]   res_cnt;
  logic [AW-1:0] ent_addr;
  logic [1:0]    ent_mark;
  logic [7:0]    ent_old;
  logic [7:0]    ent_new;

  gurwj_ram #(
    .WIDTH (8),
    .DEPTH (IMAGE_BYTES)
  ) u_image (
    .clk_i   (clk_i),
    .addr_i  (img_addr),
    .we_i    (img_we),
    .wdata_i (img_wdata),
    .rdata_o (img_rdata)
  );

  gurwj_ram #(
    .WIDTH (JW),
    .DEPTH (JOURNAL_DEPTH)
  ) u_journal (
    .clk_i   (clk_i),
    .addr_i  (jrn_addr),
    .we_i    (jrn_we),
    .wdata_i (jrn_wdata),
    .rdata_o (jrn_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  // quotient estimate straight from the input port, registered at accept
  assign quo_prod = 33'(address_i) * 33'(RECIP);

  // remainder of the captured address
  assign qn_full = 32'(quo_q) * 32'(IMAGE_BYTES);
  assign rem12   = addr_q - qn_full[11:0];
  assign wa      = WRAP_ID ? AW'({20'b0, addr_q}) : AW'({20'b0, rem12});

  assign cur_m1  = cursor_q - CW'(1);
  assign rp_m1   = rp_q - CW'(1);
  assign rp_p1   = rp_q + CW'(1);
  assign cnt_inc = (cnt_q == COUNT_MAX) ? cnt_q : (cnt_q + 11'd1);

  // journal entry fields from the read port
  assign ent_addr = jrn_rdata[JW-1:AD_LSB];
  assign ent_mark = jrn_rdata[AD_LSB-1:MK_LSB];
  assign ent_old  = jrn_rdata[MK_LSB-1:OLD_LSB];
  assign ent_new  = jrn_rdata[OLD_LSB-1:NEW_LSB];

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cursor_d    = cursor_q;
    top_d       = top_q;
    ps_d        = ps_q;
    rp_d        = rp_q;
    cnt_d       = cnt_q;
    op_d        = op_q;
    addr_d      = addr_q;
    value_d     = value_q;
    mark_d      = mark_q;
    quo_d       = quo_q;
    waddr_d     = waddr_q;
    rd_hold_d   = rd_hold_q;
    st_hold_d   = st_hold_q;
    cnt_hold_d  = cnt_hold_q;
    rd_out_d    = rd_out_q;
    st_out_d    = st_out_q;
    cnt_out_d   = cnt_out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    img_addr  = waddr_q;
    img_we    = 1'b0;
    img_wdata = 8'd0;
    jrn_addr  = cursor_q[JIW-1:0];
    jrn_we    = 1'b0;
    jrn_wdata = jrn_rdata;

    done    = 1'b0;
    res_rd  = 8'd0;
    res_st  = ST_OK;
    res_cnt = 11'd0;

    unique case (state_q)
      S_CLEAR: begin
        // zero the image one byte a cycle
        img_addr = clr_q;
        img_we   = 1'b1;
        clr_d    = clr_q + AW'(1);
        if (clr_q == AW'(IMAGE_BYTES - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = opcode_i;
          addr_d  = address_i;
          value_d = value_i;
          mark_d  = mark_i;
          quo_d   = quo_prod[32:24];
          state_d = S_DEC;
        end
      end

      S_DEC: begin
        waddr_d = wa;
        unique case (op_q)
          OP_WRITE: begin
            if (cursor_q == CW'(JOURNAL_DEPTH)) begin
              done   = 1'b1;
              res_st = ST_FULL;
            end else begin
              // fetch the old byte
              img_addr = wa;
              state_d  = S_WR;
            end
          end
          OP_READ: begin
            img_addr = wa;
            state_d  = S_RD;
          end
          OP_UNDO: begin
            if (cursor_q == CW'(0)) begin
              done   = 1'b1;
              res_st = ST_NONE;
            end else begin
              jrn_addr = cur_m1[JIW-1:0];
              rp_d     = cur_m1;
              cnt_d    = 11'd0;
              state_d  = S_UNDO;
            end
          end
          OP_REDO: begin
            if (cursor_q < top_q) begin
              jrn_addr = cursor_q[JIW-1:0];
              rp_d     = cursor_q;
              cnt_d    = 11'd0;
              state_d  = S_REDO;
            end else begin
              done   = 1'b1;
              res_st = ST_NONE;
            end
          end
          OP_OPEN: begin
            ps_d = 1'b1;
            done = 1'b1;
          end
          OP_CLOSE: begin
            ps_d = 1'b0;
            if (!ps_q && (cursor_q != CW'(0))) begin
              // read back the newest live entry to add the end mark
              jrn_addr = cur_m1[JIW-1:0];
              state_d  = S_CLOSE;
            end else begin
              done = 1'b1;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end

      S_WR: begin
        img_addr  = waddr_q;
        img_we    = 1'b1;
        img_wdata = value_q;
        jrn_addr  = cursor_q[JIW-1:0];
        jrn_we    = 1'b1;
        jrn_wdata = {waddr_q, mark_q | {1'b0, ps_q}, img_rdata, value_q};
        cursor_d  = cursor_q + CW'(1);
        top_d     = cursor_q + CW'(1);  // drops redo history
        ps_d      = 1'b0;
        done      = 1'b1;
      end

      S_RD: begin
        done   = 1'b1;
        res_rd = img_rdata;
      end

      S_UNDO: begin
        // entry rp_q is on the read port: restore its old byte
        img_addr  = ent_addr;
        img_we    = 1'b1;
        img_wdata = ent_old;
        cursor_d  = rp_q;
        cnt_d     = cnt_inc;
        if (ent_mark[GRP_START_BIT] || (rp_q == CW'(0))) begin
          done    = 1'b1;
          res_cnt = cnt_inc;
        end else begin
          jrn_addr = rp_m1[JIW-1:0];
          rp_d     = rp_m1;
        end
      end

      S_REDO: begin
        // entry rp_q is on the read port: reapply its new byte
        img_addr  = ent_addr;
        img_we    = 1'b1;
        img_wdata = ent_new;
        cursor_d  = rp_p1;
        cnt_d     = cnt_inc;
        if (ent_mark[GRP_END_BIT] || (rp_p1 == top_q)) begin
          done    = 1'b1;
          res_cnt = cnt_inc;
        end else begin
          jrn_addr = rp_p1[JIW-1:0];
          rp_d     = rp_p1;
        end
      end

      S_CLOSE: begin
        jrn_addr  = cur_m1[JIW-1:0];
        jrn_we    = 1'b1;
        jrn_wdata = jrn_rdata | (JW'(1) << (MK_LSB + GRP_END_BIT));
        done      = 1'b1;
      end

      S_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          rd_out_d    = rd_hold_q;
          st_out_d    = st_hold_q;
          cnt_out_d   = cnt_hold_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // finished item: straight to the output register, else park it
    if (done) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        rd_out_d    = res_rd;
        st_out_d    = res_st;
        cnt_out_d   = res_cnt;
        state_d     = S_IDLE;
      end else begin
        rd_hold_d  = res_rd;
        st_hold_d  = res_st;
        cnt_hold_d = res_cnt;
        state_d    = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cursor_q    <= '0;
      top_q       <= '0;
      ps_q        <= 1'b0;
      rp_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cursor_q    <= cursor_d;
      top_q       <= top_d;
      ps_q        <= ps_d;
      rp_q        <= rp_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    addr_q     <= addr_d;
    value_q    <= value_d;
    mark_q     <= mark_d;
    quo_q      <= quo_d;
    waddr_q    <= waddr_d;
    rd_hold_q  <= rd_hold_d;
    st_hold_q  <= st_hold_d;
    cnt_hold_q <= cnt_hold_d;
    rd_out_q   <= rd_out_d;
    st_out_q   <= st_out_d;
    cnt_out_q  <= cnt_out_d;
  end

  assign out_valid_o       = out_valid_q;
  assign read_data_o       = rd_out_q;
  assign status_o          = st_out_q;
  assign entries_applied_o = cnt_out_q;

  // live entries never pass the redo limit
  a_cursor_le_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= top_q)
    else $error("cursor beyond top");

  // redo limit stays inside the journal
  a_top_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= CW'(JOURNAL_DEPTH))
    else $error("top beyond journal depth");

  // undo walk: the entry on the read port sits just below the cursor
  a_undo_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UNDO) |-> (cursor_q == rp_q + CW'(1)))
    else $error("undo read pointer out of step with cursor");

  // redo walk: the entry on the read port is at the cursor and reachable
  a_redo_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REDO) |-> ((rp_q == cursor_q) && (rp_q < top_q)))
    else $error("redo read pointer out of step with cursor");

  // the journal is never written and no item is taken while the image is being cleared
  a_no_jrn_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (!jrn_we && !in_ready_o))
    else $error("journal written or item taken during clearing pass");

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the grouped undo/redo write journal: a tracker
// mirrors the image and the journal, predicts one reply per accepted command
// and compares replies in order while both channels idle at random
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gurwj_pkg::*;

  localparam int unsigned IMAGE_BYTES   = 4096;
  localparam int unsigned JOURNAL_DEPTH = 1024;

  // opcodes the block has no use for
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // write mark values
  localparam logic [1:0] MARK_NONE = 2'b00;
  localparam logic [1:0] MARK_HEAD = 2'b01;
  localparam logic [1:0] MARK_TAIL = 2'b10;
  localparam logic [1:0] MARK_BOTH = 2'b11;

  // ample for the slowest legal run, clearing pass included
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned SETTLE      = 50;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [1:0]  status;
    logic [10:0] applied;
  } reply_t;

  typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SLUGGISH, RX_BEAT} rx_mode_e;

  // mirror of the image and the journal, with the replies still owed
  class journal_tracker;
    logic [7:0]  image [IMAGE_BYTES];
    logic [11:0] ent_addr [JOURNAL_DEPTH];
    logic [1:0]  ent_mark [JOURNAL_DEPTH];
    logic [7:0]  ent_old [JOURNAL_DEPTH];
    logic [7:0]  ent_new [JOURNAL_DEPTH];
    int unsigned live_count;
    int unsigned reach_count;
    bit          start_armed;
    reply_t      replies_due[$];
    int unsigned mismatches;

    function new();
      foreach (image[i]) image[i] = 8'h00;
      live_count  = 0;
      reach_count = 0;
      start_armed = 1'b0;
      mismatches  = 0;
    endfunction

    // apply one accepted command and queue the reply it owes
    function void note_command(logic [2:0] op, logic [11:0] ad, logic [7:0] vl,
                               logic [1:0] mk);
      reply_t      r;
      int unsigned a;
      int unsigned walked;
      r      = '0;
      a      = ad % IMAGE_BYTES;
      walked = 0;
      case (op)
        OP_WRITE: begin
          if (live_count >= JOURNAL_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            ent_addr[live_count] = 12'(a);
            ent_mark[live_count] = mk | {1'b0, start_armed};
            ent_old[live_count]  = image[a];
            ent_new[live_count]  = vl;
            start_armed          = 1'b0;
            image[a]             = vl;
            live_count++;
            reach_count = live_count;
          end
        end
        OP_UNDO: begin
          while (live_count > 0) begin
            live_count--;
            image[ent_addr[live_count]] = ent_old[live_count];
            walked++;
            if (ent_mark[live_count][GRP_START_BIT]) break;
          end
          if (walked == 0) r.status = ST_NONE;
        end
        OP_REDO: begin
          while (live_count < reach_count && live_count < JOURNAL_DEPTH) begin
            image[ent_addr[live_count]] = ent_new[live_count];
            walked++;
            live_count++;
            if (ent_mark[live_count - 1][GRP_END_BIT]) break;
          end
          if (walked == 0) r.status = ST_NONE;
        end
        OP_OPEN: start_armed = 1'b1;
        OP_CLOSE: begin
          // a pending start swallows the close
          if (!start_armed && live_count > 0)
            ent_mark[live_count - 1][GRP_END_BIT] = 1'b1;
          start_armed = 1'b0;
        end
        OP_READ: r.read_data = image[a];
        default: ;
      endcase
      r.applied = (walked > COUNT_MAX) ? COUNT_MAX : 11'(walked);
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic [7:0] rd, logic [1:0] st, logic [10:0] n);
      reply_t want;
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected item read_data %0d status %0d entries_applied %0d",
                 $time, rd, st, n);
        mismatches++;
        return;
      end
      want = replies_due.pop_front();
      if (rd !== want.read_data) begin
        $display("%0t: read_data expected %0d actual %0d", $time, want.read_data, rd);
        mismatches++;
      end
      if (st !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, st);
        mismatches++;
      end
      if (n !== want.applied) begin
        $display("%0t: entries_applied expected %0d actual %0d", $time, want.applied, n);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [2:0]  opcode_i    = OP_READ;
  logic [11:0] address_i   = 12'h000;
  logic [7:0]  value_i     = 8'h00;
  logic [1:0]  mark_i      = MARK_NONE;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  read_data_o;
  logic [1:0]  status_o;
  logic [10:0] entries_applied_o;

  journal_tracker tracker = new();

  // sender pacing
  int unsigned burst_left = 0;
  bit          offering   = 1'b0;
  logic [11:0] addr_pool [16];

  // receiver pacing; hold_req asks for one long hold-off
  logic        hold_req   = 1'b0;
  bit          hold_done  = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned rx_window  = 0;
  rx_mode_e    rx_mode    = RX_STREAM;
  int unsigned cycle_cnt  = 0;

  grouped_undo_redo_write_journal_unit #(
    .IMAGE_BYTES  (IMAGE_BYTES),
    .JOURNAL_DEPTH(JOURNAL_DEPTH)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .address_i        (address_i),
    .value_i          (value_i),
    .mark_i           (mark_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .read_data_o      (read_data_o),
    .status_o         (status_o),
    .entries_applied_o(entries_applied_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // offer one command, hold it until taken, then pace the next one
  task automatic send_cmd(input logic [2:0] op, input logic [11:0] ad,
                          input logic [7:0] vl, input logic [1:0] mk);
    int unsigned gap;
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    address_i  <= ad;
    value_i    <= vl;
    mark_i     <= mk;
    offering   = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_command(op, ad, vl, mk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // either a long back-to-back burst or a short one after a gap
      if ($urandom_range(0, 3) == 0) begin
        gap        = 0;
        burst_left = $urandom_range(20, 60);
      end else begin
        gap        = $urandom_range(1, 10);
        burst_left = $urandom_range(0, 15);
      end
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        offering   = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // lower valid unless the last send already did so in this step
  task automatic drop_valid();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering   = 1'b0;
    end
  endtask

  task automatic pause_until_drained();
    drop_valid();
    while (tracker.replies_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [11:0] pick_addr();
    return addr_pool[$urandom_range(0, 15)];
  endfunction

  // mostly well-formed groups with random content, plus loose undo, redo,
  // reads, single writes and noise including broken groups
  task automatic run_mixed(input int unsigned n_items);
    int unsigned done_items;
    int unsigned pick;
    int unsigned k;
    logic [2:0]  op;
    done_items = 0;
    while (done_items < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_cmd(OP_OPEN, 12'($urandom), 8'($urandom), 2'($urandom));
        k = $urandom_range(1, 5);
        repeat (k) send_cmd(OP_WRITE, pick_addr(), 8'($urandom), 2'($urandom));
        done_items += k + 1;
        // an open group now and then is left unclosed
        if ($urandom_range(0, 4) != 0) begin
          send_cmd(OP_CLOSE, 12'($urandom), 8'($urandom), 2'($urandom));
          done_items++;
        end
      end else begin
        if (pick < 55)
          op = OP_UNDO;
        else if (pick < 67)
          op = OP_REDO;
        else if (pick < 80)
          op = OP_READ;
        else if (pick < 90)
          op = OP_WRITE;
        else
          op = 3'($urandom);
        if (op == OP_READ && pick < 80)
          send_cmd(op, pick_addr(), 8'($urandom), 2'($urandom));
        else
          send_cmd(op, 12'($urandom), 8'($urandom), 2'($urandom));
        // spare opcodes change nothing in the block and do not count
        if (op <= OP_READ) done_items++;
      end
    end
  endtask

  // receiver: check every reply taken, stall on a pattern of its own
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_reply(read_data_o, status_o, entries_applied_o);
    if (hold_req && !hold_done) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (rx_window == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(0, 3));
      rx_window = $urandom_range(8, 80);
    end else begin
      rx_window--;
    end
    if (hold_left > 0) begin
      // long hold-off so the block backs up and stalls its input
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        RX_STREAM:   out_ready_i <= 1'b1;
        RX_COIN:     out_ready_i <= 1'($urandom_range(0, 1));
        RX_SLUGGISH: out_ready_i <= ($urandom_range(0, 3) == 0);
        default:     out_ready_i <= (rx_window % 3 != 0);
      endcase
    end
  end

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    foreach (addr_pool[i]) addr_pool[i] = 12'($urandom);
    addr_pool[0] = 12'h000;
    addr_pool[1] = 12'hfff;

    // reset; the block then clears its image before taking items
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty journal, extremes, grouping and the close corner cases
    send_cmd(OP_READ,  12'h000, 8'h00, MARK_NONE);
    send_cmd(OP_UNDO,  12'h000, 8'h00, MARK_NONE);   // nothing to undo
    send_cmd(OP_REDO,  12'hfff, 8'hff, MARK_BOTH);   // nothing to redo
    send_cmd(OP_CLOSE, 12'h000, 8'h00, MARK_NONE);   // close with no live entry
    send_cmd(OP_WRITE, 12'hfff, 8'hff, MARK_NONE);
    send_cmd(OP_WRITE, 12'h000, 8'h00, MARK_BOTH);
    send_cmd(OP_OPEN,  12'h000, 8'h00, MARK_NONE);
    send_cmd(OP_WRITE, 12'h800, 8'ha5, MARK_NONE);   // picks up pending start
    send_cmd(OP_WRITE, 12'h800, 8'h5a, MARK_TAIL);
    send_cmd(OP_CLOSE, 12'h000, 8'h00, MARK_NONE);
    send_cmd(OP_OPEN,  12'h000, 8'h00, MARK_NONE);
    send_cmd(OP_CLOSE, 12'h000, 8'h00, MARK_NONE);   // close with start pending
    send_cmd(OP_WRITE, 12'h123, 8'h80, MARK_NONE);
    send_cmd(OP_CLOSE, 12'h000, 8'h00, MARK_NONE);   // end mark on newest entry
    send_cmd(OP_READ,  12'hfff, 8'h00, MARK_NONE);
    send_cmd(OP_UNDO,  12'h000, 8'h00, MARK_NONE);   // walks back to the start
    send_cmd(OP_READ,  12'h800, 8'h00, MARK_NONE);
    send_cmd(OP_REDO,  12'h000, 8'h00, MARK_NONE);
    send_cmd(OP_REDO,  12'h000, 8'h00, MARK_NONE);
    send_cmd(OP_REDO,  12'h000, 8'h00, MARK_NONE);   // redo history exhausted
    send_cmd(OP_SPARE_6, 12'hfff, 8'hff, MARK_BOTH);
    send_cmd(OP_SPARE_7, 12'h555, 8'haa, MARK_HEAD);
    send_cmd(OP_UNDO,  12'h000, 8'h00, MARK_NONE);
    send_cmd(OP_WRITE, 12'h7ff, 8'h7f, MARK_HEAD);   // cuts off redo
    send_cmd(OP_REDO,  12'h000, 8'h00, MARK_NONE);

    // random groups, with one long receiver hold-off early on
    hold_req <= 1'b1;
    run_mixed(150);

    // sender pause until every reply is in, then rewind the journal
    pause_until_drained();
    while (tracker.live_count > 0)
      send_cmd(OP_UNDO, 12'($urandom), 8'($urandom), 2'($urandom));
    send_cmd(OP_CLOSE, 12'($urandom), 8'($urandom), 2'($urandom));

    // fill the journal with start-free entries and rare end marks
    while (tracker.live_count < JOURNAL_DEPTH) begin
      if ($urandom_range(0, 19) == 0)
        send_cmd(OP_READ, 12'($urandom), 8'($urandom), 2'($urandom));
      else
        send_cmd(OP_WRITE, 12'($urandom), 8'($urandom),
                 ($urandom_range(0, 39) == 0) ? MARK_TAIL : MARK_NONE);
    end

    // full journal: writes are refused and leave state alone
    repeat (4) send_cmd(OP_WRITE, 12'($urandom), 8'($urandom), 2'($urandom));
    send_cmd(OP_OPEN,  12'($urandom), 8'($urandom), 2'($urandom));
    send_cmd(OP_WRITE, 12'($urandom), 8'($urandom), 2'($urandom));
    send_cmd(OP_CLOSE, 12'($urandom), 8'($urandom), 2'($urandom));
    send_cmd(OP_READ,  pick_addr(), 8'($urandom), 2'($urandom));

    // one undo walks the whole journal, then redo walks forward again
    send_cmd(OP_UNDO, 12'($urandom), 8'($urandom), 2'($urandom));
    send_cmd(OP_READ, pick_addr(), 8'($urandom), 2'($urandom));
    repeat (4) send_cmd(OP_REDO, 12'($urandom), 8'($urandom), 2'($urandom));
    send_cmd(OP_UNDO, 12'($urandom), 8'($urandom), 2'($urandom));

    run_mixed(40);

    // drain, let the block settle, then judge
    pause_until_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.replies_due.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> sim.f
design/gurwj_pkg.sv
design/gurwj_ram.sv
design/grouped_undo_redo_write_journal_unit.sv
tb/tb.sv
